/* hw/rtl/bbvp_pkg.sv */
`default_nettype none
// ============================================================================
// bbvp_pkg: shared types and constants of the buck-boost voltage compensator
// Holds the beat layouts, the register map, the mode codes, the loop
// coefficients and the duty clamp.
// ============================================================================
package bbvp_pkg;

    localparam int ADC_BITS       = 12;
    localparam int DUTY_FRAC_BITS = 12;

    localparam int GAIN_FRAC = 12;
    localparam int COEF_FRAC = 8;
    localparam int ERR_W     = 18;
    localparam int ACC_W     = 32;
    localparam int DUTY_W    = 13;
    localparam int GAIN_W    = 16;
    localparam int OFS_W     = 13;
    localparam int PER_W     = 16;
    localparam int VREF_W    = 13;
    localparam int CMP_W     = 16;
    localparam int SPT_W     = 15;
    localparam int CLAMP_W   = ACC_W - COEF_FRAC;

    localparam int MUL_A_W = ERR_W;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_BUCK  = 2'd1;
    localparam logic [1:0] MODE_BOOST = 2'd2;
    localparam logic [1:0] MODE_MIX   = 2'd3;

    localparam int CFG_ADDR_W = 5;
    localparam logic [2:0] REG_CAL_GAIN       = 3'd0;
    localparam logic [2:0] REG_CAL_OFFSET     = 3'd1;
    localparam logic [2:0] REG_MIN_BUCK       = 3'd2;
    localparam logic [2:0] REG_MIN_BOOST      = 3'd3;
    localparam logic [2:0] REG_TIMER_PERIOD   = 3'd4;
    localparam logic [2:0] REG_BUCK_FIX_BOOST = 3'd5;
    localparam logic [2:0] REG_BUCK_FIX_MIX   = 3'd6;
    localparam logic [2:0] REG_BOOST_FIX_BUCK = 3'd7;

    localparam logic signed [MUL_B_W-1:0] BUCK_B0  = 17'sd5203;
    localparam logic signed [MUL_B_W-1:0] BUCK_B1  = -17'sd10246;
    localparam logic signed [MUL_B_W-1:0] BUCK_B2  = 17'sd5044;
    localparam logic signed [MUL_B_W-1:0] BOOST_B0 = 17'sd8860;
    localparam logic signed [MUL_B_W-1:0] BOOST_B1 = -17'sd17445;
    localparam logic signed [MUL_B_W-1:0] BOOST_B2 = 17'sd8588;

    typedef struct packed {
        logic [1:0]          mode;
        logic [DUTY_W-1:0]   boost_max_duty;
        logic [DUTY_W-1:0]   buck_max_duty;
        logic                pwm_enable;
        logic                mode_change;
        logic [VREF_W-1:0]   voltage_ref;
        logic [ADC_BITS-1:0] adc_sample;
    } in_t;

    localparam int IN_BITS    = $bits(in_t) - 2;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [CMP_W-1:0]  boost_compare;
        logic [SPT_W-1:0]  sample_point;
        logic [CMP_W-1:0]  buck_compare;
        logic [DUTY_W-1:0] boost_duty;
        logic [DUTY_W-1:0] buck_duty;
    } res_t;

    localparam int RES_BITS    = $bits(res_t);
    localparam int OUT_TDATA_W = ((RES_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [GAIN_W-1:0] cal_gain;
        logic [OFS_W-1:0]  cal_offset;
        logic [DUTY_W-1:0] min_buck_duty;
        logic [DUTY_W-1:0] boost_floor_duty;
        logic [PER_W-1:0]  timer_period;
        logic [DUTY_W-1:0] buck_fixed_in_boost;
        logic [DUTY_W-1:0] buck_fixed_in_mix;
        logic [DUTY_W-1:0] boost_fixed_in_buck;
    } cfg_t;

    // Arithmetic shift by the coefficient fraction, then ceiling, then floor.
    function automatic logic [DUTY_W-1:0] clamp_duty(
        input logic [ACC_W-1:0]  acc,
        input logic [DUTY_W-1:0] hi,
        input logic [DUTY_W-1:0] lo
    );
        logic signed [CLAMP_W-1:0] d;
        logic signed [CLAMP_W-1:0] hi_s;
        logic signed [CLAMP_W-1:0] lo_s;
        d    = $signed(acc[ACC_W-1:COEF_FRAC]);
        hi_s = $signed({{(CLAMP_W-DUTY_W){1'b0}}, hi});
        lo_s = $signed({{(CLAMP_W-DUTY_W){1'b0}}, lo});
        if (d > hi_s)
        begin
            d = hi_s;
        end
        if (d < lo_s)
        begin
            d = lo_s;
        end
        return d[DUTY_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/bbvp_cfg_regs.sv */
`default_nettype none
// ============================================================================
// bbvp_cfg_regs: configuration register file
// APB-style slave holding calibration, duty limits, fixed duties and the
// timer period. Writes land in the access cycle; reads are combinational.
// ============================================================================
module bbvp_cfg_regs
    import bbvp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_CAL_GAIN:       cfg_next.cal_gain            = pwdata[GAIN_W-1:0];
                REG_CAL_OFFSET:     cfg_next.cal_offset          = pwdata[OFS_W-1:0];
                REG_MIN_BUCK:       cfg_next.min_buck_duty       = pwdata[DUTY_W-1:0];
                REG_MIN_BOOST:      cfg_next.boost_floor_duty    = pwdata[DUTY_W-1:0];
                REG_TIMER_PERIOD:   cfg_next.timer_period        = pwdata[PER_W-1:0];
                REG_BUCK_FIX_BOOST: cfg_next.buck_fixed_in_boost = pwdata[DUTY_W-1:0];
                REG_BUCK_FIX_MIX:   cfg_next.buck_fixed_in_mix   = pwdata[DUTY_W-1:0];
                REG_BOOST_FIX_BUCK: cfg_next.boost_fixed_in_buck = pwdata[DUTY_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CAL_GAIN:       prdata = {{(32-GAIN_W){1'b0}}, cfg_reg.cal_gain};
            REG_CAL_OFFSET:     prdata = {{(32-OFS_W){1'b0}}, cfg_reg.cal_offset};
            REG_MIN_BUCK:       prdata = {{(32-DUTY_W){1'b0}}, cfg_reg.min_buck_duty};
            REG_MIN_BOOST:      prdata = {{(32-DUTY_W){1'b0}}, cfg_reg.boost_floor_duty};
            REG_TIMER_PERIOD:   prdata = {{(32-PER_W){1'b0}}, cfg_reg.timer_period};
            REG_BUCK_FIX_BOOST: prdata = {{(32-DUTY_W){1'b0}}, cfg_reg.buck_fixed_in_boost};
            REG_BUCK_FIX_MIX:   prdata = {{(32-DUTY_W){1'b0}}, cfg_reg.buck_fixed_in_mix};
            REG_BOOST_FIX_BUCK: prdata = {{(32-DUTY_W){1'b0}}, cfg_reg.boost_fixed_in_buck};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cal_gain            <= 16'd4096;
            cfg_reg.cal_offset          <= 13'd0;
            cfg_reg.min_buck_duty       <= 13'd0;
            cfg_reg.boost_floor_duty    <= 13'd0;
            cfg_reg.timer_period        <= 16'd65535;
            cfg_reg.buck_fixed_in_boost <= 13'd3809;
            cfg_reg.buck_fixed_in_mix   <= 13'd3277;
            cfg_reg.boost_fixed_in_buck <= 13'd3809;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/bbvp_mul.sv */
`default_nettype none
// ============================================================================
// bbvp_mul: shared signed multiplier
// One signed 18 by 17 bit multiplier with a registered product, loaded only
// when enabled so that a result can be held while it waits.
// ============================================================================
module bbvp_mul
    import bbvp_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic signed [MUL_A_W-1:0] a,
    input  wire logic signed [MUL_B_W-1:0] b,
    output logic signed      [MUL_P_W-1:0] p
);

    logic signed [MUL_P_W-1:0] prod_reg;
    logic signed [MUL_P_W-1:0] prod_next;

    assign prod_next = en ? (MUL_P_W'(a) * MUL_P_W'(b)) : prod_reg;
    assign p         = prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule
`default_nettype wire

/* hw/rtl/bbvp_ctrl.sv */
`default_nettype none
// ============================================================================
// bbvp_ctrl: compensator sequencer and loop state
// Steps one sample through calibration, the three PID taps, the clamp and
// the two timer compares, feeding the shared multiplier one operand pair
// per multiply step.
// ============================================================================
module bbvp_ctrl
    import bbvp_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire in_t                       in_item,
    input  wire cfg_t                      cfg,
    output logic                           mul_en,
    output logic signed [MUL_A_W-1:0]      mul_a,
    output logic signed [MUL_B_W-1:0]      mul_b,
    input  wire logic signed [MUL_P_W-1:0] mul_p,
    output logic                           res_valid,
    input  wire logic                      res_ready,
    output res_t                           res
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CAL   = 4'd1;
    localparam logic [3:0] S_E1    = 4'd2;
    localparam logic [3:0] S_E2    = 4'd3;
    localparam logic [3:0] S_E0    = 4'd4;
    localparam logic [3:0] S_ACC   = 4'd5;
    localparam logic [3:0] S_CLAMP = 4'd6;
    localparam logic [3:0] S_MBK   = 4'd7;
    localparam logic [3:0] S_MBO   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]              state_reg, state_next;
    in_t                     in_reg, in_next;
    logic signed [ERR_W-1:0] e0_reg, e0_next;
    logic signed [ERR_W-1:0] err_prev_reg, err_prev_next;
    logic signed [ERR_W-1:0] err_prev2_reg, err_prev2_next;
    logic [ACC_W-1:0]        accum_reg, accum_next;
    logic [ACC_W-1:0]        work_reg, work_next;
    logic [DUTY_W-1:0]       held_buck_reg, held_buck_next;
    logic [DUTY_W-1:0]       held_boost_reg, held_boost_next;
    logic [CMP_W-1:0]        bc_reg, bc_next;

    logic                    use_buck;
    logic [ERR_W-1:0]        vcal;
    logic [ERR_W-1:0]        err_calc;
    logic [DUTY_W-1:0]       buck_clamped;
    logic [DUTY_W-1:0]       boost_clamped;
    logic [CMP_W-1:0]        scaled;

    assign use_buck = (in_reg.mode == MODE_BUCK);
    assign vcal     = mul_p[GAIN_FRAC+ERR_W-1:GAIN_FRAC];
    assign err_calc = {{(ERR_W-VREF_W){1'b0}}, in_reg.voltage_ref} - vcal
                    - {{(ERR_W-OFS_W){cfg.cal_offset[OFS_W-1]}}, cfg.cal_offset};
    assign buck_clamped  = clamp_duty(work_reg, in_reg.buck_max_duty, cfg.min_buck_duty);
    assign boost_clamped = clamp_duty(work_reg, in_reg.boost_max_duty, cfg.boost_floor_duty);
    assign scaled        = mul_p[DUTY_FRAC_BITS+CMP_W-1:DUTY_FRAC_BITS];

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);

    always_comb
    begin
        res.buck_duty     = held_buck_reg;
        res.boost_duty    = held_boost_reg;
        res.buck_compare  = bc_reg;
        res.sample_point  = bc_reg[CMP_W-1:1];
        res.boost_compare = cfg.timer_period - scaled;
    end

    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            S_CAL:
            begin
                mul_a = $signed({{(MUL_A_W-ADC_BITS){1'b0}}, in_reg.adc_sample});
                mul_b = $signed({1'b0, cfg.cal_gain});
            end
            S_E1:
            begin
                mul_a = err_prev_reg;
                mul_b = use_buck ? BUCK_B1 : BOOST_B1;
            end
            S_E2:
            begin
                mul_a = err_prev2_reg;
                mul_b = use_buck ? BUCK_B2 : BOOST_B2;
            end
            S_E0:
            begin
                mul_a = e0_reg;
                mul_b = use_buck ? BUCK_B0 : BOOST_B0;
            end
            S_MBK:
            begin
                mul_a = $signed({{(MUL_A_W-DUTY_W){1'b0}}, held_buck_reg});
                mul_b = $signed({1'b0, cfg.timer_period});
            end
            S_MBO:
            begin
                mul_a = $signed({{(MUL_A_W-DUTY_W){1'b0}}, held_boost_reg});
                mul_b = $signed({1'b0, cfg.timer_period});
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        in_next         = in_reg;
        e0_next         = e0_reg;
        err_prev_next   = err_prev_reg;
        err_prev2_next  = err_prev2_reg;
        accum_next      = accum_reg;
        work_next       = work_reg;
        held_buck_next  = held_buck_reg;
        held_boost_next = held_boost_reg;
        bc_next         = bc_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    in_next    = in_item;
                    state_next = S_CAL;
                end
            end
            S_CAL:
            begin
                state_next = S_E1;
            end
            S_E1:
            begin
                e0_next    = $signed(err_calc);
                work_next  = in_reg.mode_change ? '0 : accum_reg;
                state_next = S_E2;
            end
            S_E2:
            begin
                work_next  = work_reg + mul_p[ACC_W-1:0];
                state_next = S_E0;
            end
            S_E0:
            begin
                work_next  = work_reg + mul_p[ACC_W-1:0];
                state_next = S_ACC;
            end
            S_ACC:
            begin
                work_next  = work_reg + mul_p[ACC_W-1:0];
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                if (in_reg.mode == MODE_IDLE)
                begin
                    err_prev_next  = '0;
                    err_prev2_next = '0;
                    accum_next     = '0;
                end
                else
                begin
                    err_prev_next  = e0_reg;
                    err_prev2_next = err_prev_reg;
                    accum_next     = work_reg;
                end
                unique case (in_reg.mode)
                    MODE_IDLE:
                    begin
                        held_buck_next  = held_buck_reg;
                        held_boost_next = held_boost_reg;
                    end
                    MODE_BUCK:
                    begin
                        held_buck_next  = buck_clamped;
                        held_boost_next = cfg.boost_fixed_in_buck;
                    end
                    MODE_BOOST:
                    begin
                        held_buck_next  = cfg.buck_fixed_in_boost;
                        held_boost_next = boost_clamped;
                    end
                    MODE_MIX:
                    begin
                        held_buck_next  = cfg.buck_fixed_in_mix;
                        held_boost_next = boost_clamped;
                    end
                    default:
                    begin
                        held_buck_next  = held_buck_reg;
                        held_boost_next = held_boost_reg;
                    end
                endcase
                if (!in_reg.pwm_enable)
                begin
                    held_buck_next = cfg.min_buck_duty;
                end
                state_next = S_MBK;
            end
            S_MBK:
            begin
                state_next = S_MBO;
            end
            S_MBO:
            begin
                bc_next    = scaled;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            err_prev_reg   <= '0;
            err_prev2_reg  <= '0;
            accum_reg      <= '0;
            held_buck_reg  <= '0;
            held_boost_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            err_prev_reg   <= err_prev_next;
            err_prev2_reg  <= err_prev2_next;
            accum_reg      <= accum_next;
            held_buck_reg  <= held_buck_next;
            held_boost_reg <= held_boost_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg   <= in_next;
        e0_reg   <= e0_next;
        work_reg <= work_next;
        bc_reg   <= bc_next;
    end

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_CAL))
        else $error("accepted beat did not start the calibration step");

    a_idle_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLAMP && in_reg.mode == MODE_IDLE)
        |=> (accum_reg == '0 && err_prev_reg == '0 && err_prev2_reg == '0))
        else $error("idle mode left loop history behind");

    a_pwm_off_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLAMP && !in_reg.pwm_enable)
        |=> (held_buck_reg == $past(cfg.min_buck_duty)))
        else $error("buck duty not forced to its floor with PWM off");

    a_buck_fixed_boost: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLAMP && in_reg.mode == MODE_BUCK)
        |=> (held_boost_reg == $past(cfg.boost_fixed_in_buck)))
        else $error("boost duty in buck mode is not the fixed value");
`endif

endmodule
`default_nettype wire

/* hw/rtl/buck_boost_voltage_pid_top.sv */
`default_nettype none
// An accepted beat steps through S_CAL, S_E1, S_E2, S_E0, S_ACC, S_CLAMP, S_MBK,
// S_MBO and S_OUT; the single shared multiplier is used six times per sample
// (calibration, three PID taps, two timer compares). s_axis_tready is low from
// acceptance until the result enters the output register (m_axis_tvalid).
// Reset: rst_n clears loop history and held duties to zero, loads register defaults
// and empties the output register; no clearing pass is needed.
// ============================================================================
// buck_boost_voltage_pid_top: voltage-loop compensator for a buck-boost stage
// Calibrates each output-voltage sample, runs an incremental PID and returns
// the clamped duties with the timer and ADC trigger compares.
// ============================================================================
module buck_boost_voltage_pid_top
    import bbvp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [CFG_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]            pwdata,
    output logic      [31:0]            prdata,
    output logic                        pready,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // adc_sample, voltage_ref, mode_change, pwm_enable, buck_max_duty, boost_max_duty
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // mode
    input  wire logic [1:0]             s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // buck_duty, boost_duty, buck_compare, sample_point, boost_compare
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata
);

    cfg_t                      cfg;
    in_t                       in_item;
    res_t                      res;
    logic                      res_valid;
    logic                      res_ready;
    logic                      mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    logic                      out_valid_reg, out_valid_next;
    res_t                      out_data_reg, out_data_next;

    assign in_item = in_t'({s_axis_tuser, s_axis_tdata[IN_BITS-1:0]});

    bbvp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bbvp_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    bbvp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .cfg       (cfg),
        .mul_en    (mul_en),
        .mul_a     (mul_a),
        .mul_b     (mul_b),
        .mul_p     (mul_p),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-RES_BITS){1'b0}}, out_data_reg};

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb: testbench of the buck-boost voltage compensator
// Drives sample beats over the input stream and register writes over the
// configuration port, predicts every result beat with an independent model of
// the calibration, the incremental PID, the duty clamps and the timer compares,
// and checks each output beat field by field against the oldest prediction.
// ============================================================================
module tb;
    import bbvp_pkg::*;

    localparam int PID_BUCK_K0  = 5203;
    localparam int PID_BUCK_K1  = -10246;
    localparam int PID_BUCK_K2  = 5044;
    localparam int PID_BOOST_K0 = 8860;
    localparam int PID_BOOST_K1 = -17445;
    localparam int PID_BOOST_K2 = 8588;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 14;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [CFG_ADDR_W-1:0]  paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // adc_sample, voltage_ref, mode_change, pwm_enable, buck_max_duty, boost_max_duty
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // mode
    logic [1:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // buck_duty, boost_duty, buck_compare, sample_point, boost_compare
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    cfg_t               reg_mirror;
    logic signed [17:0] err_z1;
    logic signed [17:0] err_z2;
    logic [31:0]        integ_acc;
    logic [12:0]        hold_buck;
    logic [12:0]        hold_boost;

    res_t duty_expect_q[$];
    res_t got_beat;
    res_t want_beat;
    int   n_mismatch = 0;

    bit tx_gap_en    = 1'b1;
    bit rx_stall_en  = 1'b1;
    bit hold_off_req = 1'b0;
    int hold_cnt;

    buck_boost_voltage_pid_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] pid_update(
        input logic signed [17:0] e_now,
        input int                 k0,
        input int                 k1,
        input int                 k2
    );
        integ_acc = integ_acc + (int'(e_now) * k0 + int'(err_z1) * k1 + int'(err_z2) * k2);
        err_z2    = err_z1;
        err_z1    = e_now;
        return integ_acc;
    endfunction

    function automatic logic [12:0] duty_clip(
        input logic [31:0] acc,
        input logic [12:0] ceil_duty,
        input logic [12:0] floor_duty
    );
        int d;
        d = $signed(acc) >>> COEF_FRAC;
        if (d > int'(ceil_duty))
        begin
            d = int'(ceil_duty);
        end
        if (d < int'(floor_duty))
        begin
            d = int'(floor_duty);
        end
        return d[12:0];
    endfunction

    function automatic res_t run_compensator(input in_t s);
        res_t               r;
        logic [31:0]        vcal;
        logic [31:0]        diff;
        logic signed [17:0] e_now;
        logic [31:0]        acc;
        logic [31:0]        buck_prod;
        logic [31:0]        boost_prod;
        logic [31:0]        boost_cmp;
        vcal  = ((32'(s.adc_sample) * 32'(reg_mirror.cal_gain)) >> GAIN_FRAC)
              + {{19{reg_mirror.cal_offset[12]}}, reg_mirror.cal_offset};
        diff  = 32'(s.voltage_ref) - vcal;
        e_now = diff[17:0];
        if (s.mode_change)
        begin
            integ_acc = '0;
        end
        case (s.mode)
            MODE_IDLE:
            begin
                err_z1    = '0;
                err_z2    = '0;
                integ_acc = '0;
            end
            MODE_BUCK:
            begin
                acc        = pid_update(e_now, PID_BUCK_K0, PID_BUCK_K1, PID_BUCK_K2);
                hold_buck  = duty_clip(acc, s.buck_max_duty, reg_mirror.min_buck_duty);
                hold_boost = reg_mirror.boost_fixed_in_buck;
            end
            MODE_BOOST:
            begin
                acc        = pid_update(e_now, PID_BOOST_K0, PID_BOOST_K1, PID_BOOST_K2);
                hold_buck  = reg_mirror.buck_fixed_in_boost;
                hold_boost = duty_clip(acc, s.boost_max_duty, reg_mirror.boost_floor_duty);
            end
            default:
            begin
                acc        = pid_update(e_now, PID_BOOST_K0, PID_BOOST_K1, PID_BOOST_K2);
                hold_buck  = reg_mirror.buck_fixed_in_mix;
                hold_boost = duty_clip(acc, s.boost_max_duty, reg_mirror.boost_floor_duty);
            end
        endcase
        if (!s.pwm_enable)
        begin
            hold_buck = reg_mirror.min_buck_duty;
        end
        buck_prod       = 32'(hold_buck) * 32'(reg_mirror.timer_period);
        boost_prod      = 32'(hold_boost) * 32'(reg_mirror.timer_period);
        boost_cmp       = 32'(reg_mirror.timer_period) - (boost_prod >> DUTY_FRAC_BITS);
        r.buck_duty     = hold_buck;
        r.boost_duty    = hold_boost;
        r.buck_compare  = buck_prod[27:12];
        r.sample_point  = buck_prod[27:13];
        r.boost_compare = boost_cmp[15:0];
        return r;
    endfunction

    task automatic note_mismatch(input string what, input longint want_v, input longint got_v);
        n_mismatch++;
        if (n_mismatch <= 10)
        begin
            $display("mismatch in %s at %0t: expected %0d, got %0d", what, $time, want_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_beat = m_axis_tdata[RES_BITS-1:0];
            if (duty_expect_q.size() == 0)
            begin
                note_mismatch("beat with no prediction (buck_duty)", -1, got_beat.buck_duty);
            end
            else
            begin
                want_beat = duty_expect_q.pop_front();
                if (got_beat.buck_duty !== want_beat.buck_duty)
                begin
                    note_mismatch("buck_duty", want_beat.buck_duty, got_beat.buck_duty);
                end
                if (got_beat.boost_duty !== want_beat.boost_duty)
                begin
                    note_mismatch("boost_duty", want_beat.boost_duty, got_beat.boost_duty);
                end
                if (got_beat.buck_compare !== want_beat.buck_compare)
                begin
                    note_mismatch("buck_compare", want_beat.buck_compare,
                                  got_beat.buck_compare);
                end
                if (got_beat.sample_point !== want_beat.sample_point)
                begin
                    note_mismatch("sample_point", want_beat.sample_point,
                                  got_beat.sample_point);
                end
                if (got_beat.boost_compare !== want_beat.boost_compare)
                begin
                    note_mismatch("boost_compare", want_beat.boost_compare,
                                  got_beat.boost_compare);
                end
            end
        end
    end

    // Output side: random stalls, plus one long counted hold-off on request.
    initial
    begin
        forever
        begin
            if (hold_off_req)
            begin
                m_axis_tready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < HOLD_OFF_CYCLES; hold_cnt++)
                begin
                    @(posedge clk);
                end
                hold_off_req = 1'b0;
            end
            else if (rx_stall_en && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    initial
    begin
        #(5_000_000);
        $display("tb NOT OK");
        $finish;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_CAL_GAIN:       reg_mirror.cal_gain            = val[15:0];
            REG_CAL_OFFSET:     reg_mirror.cal_offset          = val[12:0];
            REG_MIN_BUCK:       reg_mirror.min_buck_duty       = val[12:0];
            REG_MIN_BOOST:      reg_mirror.boost_floor_duty    = val[12:0];
            REG_TIMER_PERIOD:   reg_mirror.timer_period        = val[15:0];
            REG_BUCK_FIX_BOOST: reg_mirror.buck_fixed_in_boost = val[12:0];
            REG_BUCK_FIX_MIX:   reg_mirror.buck_fixed_in_mix   = val[12:0];
            default:            reg_mirror.boost_fixed_in_buck = val[12:0];
        endcase
    endtask

    task automatic load_config(input cfg_t c);
        write_reg(REG_CAL_GAIN, 32'(c.cal_gain));
        write_reg(REG_CAL_OFFSET, 32'(c.cal_offset));
        write_reg(REG_MIN_BUCK, 32'(c.min_buck_duty));
        write_reg(REG_MIN_BOOST, 32'(c.boost_floor_duty));
        write_reg(REG_TIMER_PERIOD, 32'(c.timer_period));
        write_reg(REG_BUCK_FIX_BOOST, 32'(c.buck_fixed_in_boost));
        write_reg(REG_BUCK_FIX_MIX, 32'(c.buck_fixed_in_mix));
        write_reg(REG_BOOST_FIX_BUCK, 32'(c.boost_fixed_in_buck));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_sample(input in_t s);
        s_axis_tdata  <= {3'b000, s.boost_max_duty, s.buck_max_duty, s.pwm_enable,
                          s.mode_change, s.voltage_ref, s.adc_sample};
        s_axis_tuser  <= s.mode;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        duty_expect_q.push_back(run_compensator(s));
        if (tx_gap_en && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    task automatic send_fields(
        input logic [1:0]  m,
        input logic        chg,
        input logic        pwm,
        input logic [11:0] adc,
        input logic [12:0] vref,
        input logic [12:0] buck_ceil,
        input logic [12:0] boost_ceil
    );
        in_t s;
        s.mode           = m;
        s.mode_change    = chg;
        s.pwm_enable     = pwm;
        s.adc_sample     = adc;
        s.voltage_ref    = vref;
        s.buck_max_duty  = buck_ceil;
        s.boost_max_duty = boost_ceil;
        send_sample(s);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (duty_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [12:0] pick_ceiling();
        case ($urandom_range(0, 15))
            0:       return 13'd0;
            1:       return 13'd4096;
            2:       return 13'($urandom_range(0, 8191));
            default: return 13'($urandom_range(0, 4096));
        endcase
    endfunction

    // Loop traffic: vref tracks the calibrated sample so the loop settles
    // inside the clamps, unless a wide error is asked for.
    function automatic in_t make_sample(input logic [1:0] m, input bit fresh, input bit wide);
        in_t s;
        int  vtrack;
        s.mode           = m;
        s.mode_change    = fresh ? 1'b1 : ($urandom_range(0, 31) == 0);
        s.pwm_enable     = ($urandom_range(0, 9) != 0);
        s.adc_sample     = 12'($urandom);
        s.buck_max_duty  = pick_ceiling();
        s.boost_max_duty = pick_ceiling();
        if (wide)
        begin
            s.voltage_ref = 13'($urandom);
        end
        else
        begin
            vtrack = ((int'(s.adc_sample) * int'(reg_mirror.cal_gain)) >>> GAIN_FRAC)
                   + int'($signed(reg_mirror.cal_offset)) + $urandom_range(0, 256) - 128;
            if (vtrack < 0)
            begin
                vtrack = 0;
            end
            if (vtrack > 8191)
            begin
                vtrack = 8191;
            end
            s.voltage_ref = vtrack[12:0];
        end
        return s;
    endfunction

    function automatic cfg_t random_config();
        cfg_t c;
        case ($urandom_range(0, 7))
            0:       c.cal_gain = 16'hFFFF;
            1:       c.cal_gain = 16'h0000;
            2:       c.cal_gain = 16'($urandom);
            default: c.cal_gain = 16'($urandom_range(3000, 5000));
        endcase
        case ($urandom_range(0, 5))
            0:       c.cal_offset = 13'h1000;
            1:       c.cal_offset = 13'h0FFF;
            default: c.cal_offset = 13'($urandom);
        endcase
        c.min_buck_duty    = ($urandom_range(0, 5) == 0) ? 13'd4096
                                                         : 13'($urandom_range(0, 400));
        c.boost_floor_duty = ($urandom_range(0, 5) == 0) ? 13'd4096
                                                         : 13'($urandom_range(0, 400));
        case ($urandom_range(0, 7))
            0:       c.timer_period = 16'd0;
            1:       c.timer_period = 16'd1;
            2:       c.timer_period = 16'hFFFF;
            default: c.timer_period = 16'($urandom);
        endcase
        c.buck_fixed_in_boost = ($urandom_range(0, 7) == 0) ? 13'd4096
                                                             : 13'($urandom_range(0, 4096));
        c.buck_fixed_in_mix   = ($urandom_range(0, 7) == 0) ? 13'd4096
                                                             : 13'($urandom_range(0, 4096));
        c.boost_fixed_in_buck = ($urandom_range(0, 7) == 0) ? 13'd4096
                                                             : 13'($urandom_range(0, 4096));
        return c;
    endfunction

    // Runs of one mode opened by a mode change, with some wide-error runs
    // that drive the accumulator around its wrap and a share of pure noise.
    task automatic send_runs(input int n_items);
        logic [1:0] m;
        int         kind;
        int         run_len;
        int         n_sent;
        in_t        s;
        n_sent = 0;
        while (n_sent < n_items)
        begin
            kind    = $urandom_range(0, 9);
            m       = 2'($urandom_range(0, 3));
            if (m == MODE_IDLE && $urandom_range(0, 1) == 0)
            begin
                m = MODE_BUCK;
            end
            run_len = (kind == 0) ? $urandom_range(1, 4) : $urandom_range(4, 40);
            for (int i = 0; i < run_len; i++)
            begin
                if (kind == 0)
                begin
                    s             = make_sample(2'($urandom_range(0, 3)), 1'b0, 1'b1);
                    s.mode_change = 1'($urandom);
                    s.pwm_enable  = 1'($urandom);
                end
                else
                begin
                    s = make_sample(m, i == 0, kind == 1 || $urandom_range(0, 19) == 0);
                end
                send_sample(s);
                n_sent++;
            end
        end
        wait_drained();
    endtask

    task automatic test_directed_extremes();
        cfg_t c;
        send_fields(MODE_IDLE, 1'b0, 1'b1, 12'd0, 13'd0, 13'd4096, 13'd4096);
        send_fields(MODE_BUCK, 1'b1, 1'b1, 12'd0, 13'd8191, 13'd4096, 13'd4096);
        send_fields(MODE_BUCK, 1'b0, 1'b1, 12'd4095, 13'd0, 13'd4096, 13'd4096);
        send_fields(MODE_BUCK, 1'b1, 1'b1, 12'd2000, 13'd2010, 13'd4096, 13'd4096);
        send_fields(MODE_BUCK, 1'b0, 1'b0, 12'd2000, 13'd2030, 13'd4096, 13'd4096);
        send_fields(MODE_IDLE, 1'b0, 1'b0, 12'd1234, 13'd77, 13'd0, 13'd0);
        send_fields(MODE_IDLE, 1'b0, 1'b1, 12'd4095, 13'd8191, 13'd8191, 13'd8191);
        send_fields(MODE_BOOST, 1'b1, 1'b1, 12'd100, 13'd300, 13'd4096, 13'd4096);
        send_fields(MODE_MIX, 1'b0, 1'b1, 12'd4095, 13'd8191, 13'd4096, 13'd4096);
        send_fields(MODE_MIX, 1'b1, 1'b1, 12'd0, 13'd0, 13'd0, 13'd0);
        wait_drained();

        // Floors above ceilings, largest gain, most negative offset.
        c = '{cal_gain: 16'hFFFF, cal_offset: 13'h1000, min_buck_duty: 13'd4096,
              boost_floor_duty: 13'd4096, timer_period: 16'hFFFF,
              buck_fixed_in_boost: 13'd4096, buck_fixed_in_mix: 13'd0,
              boost_fixed_in_buck: 13'd4096};
        load_config(c);
        send_fields(MODE_BUCK, 1'b1, 1'b1, 12'd4095, 13'd8191, 13'd0, 13'd0);
        send_fields(MODE_BOOST, 1'b1, 1'b1, 12'd0, 13'd0, 13'd8191, 13'd8191);
        send_fields(MODE_MIX, 1'b0, 1'b0, 12'd4095, 13'd0, 13'd4096, 13'd0);
        send_fields(MODE_IDLE, 1'b0, 1'b1, 12'd0, 13'd8191, 13'd4096, 13'd4096);
        wait_drained();

        // Zero gain, largest offset, zero timer period.
        c = '{cal_gain: 16'h0000, cal_offset: 13'h0FFF, min_buck_duty: 13'd0,
              boost_floor_duty: 13'd0, timer_period: 16'd0, buck_fixed_in_boost: 13'd0,
              buck_fixed_in_mix: 13'd4096, boost_fixed_in_buck: 13'd0};
        load_config(c);
        send_fields(MODE_BUCK, 1'b1, 1'b1, 12'd4095, 13'd8191, 13'd8191, 13'd8191);
        send_fields(MODE_BOOST, 1'b0, 1'b1, 12'd1, 13'd1, 13'd4096, 13'd4096);
        send_fields(MODE_MIX, 1'b0, 1'b0, 12'd2048, 13'd4095, 13'd4096, 13'd4096);
        send_fields(MODE_BUCK, 1'b1, 1'b1, 12'd0, 13'd4096, 13'd4096, 13'd4096);
        wait_drained();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 5; ph++)
        begin
            load_config(random_config());
            send_runs(200);
        end
    endtask

    task automatic test_output_backpressure();
        hold_off_req = 1'b1;
        send_runs(40);
    endtask

    task automatic test_steady_stream();
        tx_gap_en   = 1'b0;
        rx_stall_en = 1'b0;
        load_config(random_config());
        send_runs(150);
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= MODE_IDLE;
        reg_mirror    = '{cal_gain: 16'd4096, cal_offset: 13'd0, min_buck_duty: 13'd0,
                          boost_floor_duty: 13'd0, timer_period: 16'hFFFF,
                          buck_fixed_in_boost: 13'd3809, buck_fixed_in_mix: 13'd3277,
                          boost_fixed_in_buck: 13'd3809};
        err_z1        = '0;
        err_z2        = '0;
        integ_acc     = '0;
        hold_buck     = '0;
        hold_boost    = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_random_phases();
        test_output_backpressure();
        test_steady_stream();

        if (n_mismatch == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
